// ===== hw/rtl/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

    localparam int WORD_COUNT = 32;
    localparam int WORD_BITS  = 32;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int SEL_W      = IDX_W - BIT_W;
    localparam int FREE_W     = 11;
    localparam int CAPACITY   = WORD_COUNT * WORD_BITS;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;     // item accepted, fetch addressed word
        logic modify;   // read-modify-write of addressed word, start scan
        logic scan;     // check one word of the scan
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic word_free;  // word under check has a zero bit
        logic last_word;  // word under check is the last one
    } t_dp_status;

    // position of the lowest zero bit; only meaningful if one exists
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bia_ctrl.sv =====
`default_nettype none

module bia_ctrl
    import bia_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MODIFY = 3'b010,
        S_SCAN   = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MODIFY;
                end
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.word_free || i_status.last_word) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/bia_datapath.sv =====
`default_nettype none

module bia_datapath
    import bia_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [1:0]        i_operation,
    input  wire logic [IDX_W-1:0]  i_bit_index,
    output t_dp_status             o_status,
    output logic                   o_result_strobe,
    output logic                   o_bit_was_set,
    output logic [FREE_W-1:0]      o_first_free
);

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_valid;

    logic [1:0]           r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [WORD_BITS-1:0] r_rd_data;
    logic [ADDR_W-1:0]    r_scan_ptr, r_chk_ptr;
    logic                 r_was;
    logic                 r_out_strobe, r_out_was;
    logic [FREE_W-1:0]    r_out_free;

    logic [SEL_W-1:0]     in_word, cur_word;
    logic                 in_range;
    logic [BIT_W-1:0]     cur_bit;
    logic [WORD_BITS-1:0] bit_mask, wr_data;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic                 rd_en;
    logic                 word_free, last_word;

    assign in_word  = i_bit_index[IDX_W-1:BIT_W];
    assign cur_word = r_idx[IDX_W-1:BIT_W];
    assign cur_bit  = r_idx[BIT_W-1:0];
    assign in_range = (32'(cur_word) < 32'(WORD_COUNT));
    assign bit_mask = WORD_BITS'(1) << cur_bit;
    assign wr_addr  = ADDR_W'(cur_word);

    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_rd_data;
        case (t_op'(r_op))
            OP_SET: begin
                wr_en   = i_cmd.modify && in_range;
                wr_data = r_rd_data | bit_mask;
            end
            OP_CLEAR: begin
                wr_en   = i_cmd.modify && in_range;
                wr_data = r_rd_data & ~bit_mask;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // one read port: addressed word, then the scan words in order
    always_comb begin
        rd_en   = i_cmd.load || i_cmd.modify || i_cmd.scan;
        rd_addr = r_scan_ptr;
        if (i_cmd.load) begin
            rd_addr = ADDR_W'(in_word);
        end else if (i_cmd.modify) begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                r_rd_data <= wr_data;
            end else if (r_valid[rd_addr]) begin
                r_rd_data <= mem[rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    assign word_free = (r_rd_data != {WORD_BITS{1'b1}});
    assign last_word = (r_chk_ptr == ADDR_W'(WORD_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_idx <= i_bit_index;
        end
        if (i_cmd.modify) begin
            r_was      <= in_range && r_rd_data[cur_bit];
            r_scan_ptr <= ADDR_W'(1);
            r_chk_ptr  <= '0;
        end else if (i_cmd.scan) begin
            r_scan_ptr <= r_scan_ptr + 1'b1;
            r_chk_ptr  <= r_chk_ptr + 1'b1;
        end
        if (i_cmd.scan && (word_free || last_word)) begin
            r_out_was <= r_was;
            if (word_free) begin
                r_out_free <= FREE_W'({r_chk_ptr, lowest_zero(r_rd_data)});
            end else begin
                r_out_free <= FREE_W'(CAPACITY);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= i_cmd.scan && (word_free || last_word);
        end
    end

    assign o_status.word_free = word_free;
    assign o_status.last_word = last_word;
    assign o_result_strobe    = r_out_strobe;
    assign o_bit_was_set      = r_out_was;
    assign o_first_free       = r_out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_id_allocator.sv =====
// bitmap_id_allocator: in-use bitmap of 1024 identifiers (32 words x 32 bits).
//
// Request channel: start/busy. An item (operation, bit_index) is taken at a
// clock edge with start high and busy low. Operation read leaves the map as
// is, set marks the identifier in use, clear frees it; the unused code acts
// as a read.
// Result channel: o_result_strobe is high for exactly one cycle per item and
// carries o_bit_was_set (bit before the request) and o_first_free (lowest
// free identifier after the request, 1024 when every identifier is in use).
// The receiver cannot stall; each result must be taken when it is shown.
//
// Each item is handled in order: a fetch of the addressed word, its
// read-modify-write, then a scan of one word per cycle from word 0 up to
// the first word with a zero bit, or the last word. The scan reads through
// the single word-wide read port of the bitmap memory.
// busy drops in the strobe cycle, so the next item may be taken then.
//
// Reset (i_rst_n low, synchronous) clears every per-word valid flag, so the
// whole map reads as free at once; no clearing pass is needed.
`default_nettype none

module bitmap_id_allocator
    import bia_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_operation,
    input  wire logic [IDX_W-1:0]  i_bit_index,
    output logic                   o_result_strobe,
    output logic                   o_bit_was_set,
    output logic [FREE_W-1:0]      o_first_free
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: fetch, modify, scan
    bia_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // bitmap memory, valid flags, scan pointers and result register
    bia_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_operation     (i_operation),
        .i_bit_index     (i_bit_index),
        .o_status        (dp_status),
        .o_result_strobe (o_result_strobe),
        .o_bit_was_set   (o_bit_was_set),
        .o_first_free    (o_first_free)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bia_checker.sv =====
`default_nettype none

module bia_checker
    import bia_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_result_strobe,
    input wire logic [FREE_W-1:0] o_first_free
);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // the result is shown as the block turns idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobe while busy");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_result_strobe)
        else $error("busy ended without a result");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_first_free <= FREE_W'(CAPACITY)))
        else $error("first free beyond capacity");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_first_free    (o_first_free)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the bitmap identifier allocator.
// A local copy of the in-use bitmap predicts, for every accepted item, the
// old value of the addressed bit and the lowest free identifier afterwards.
// The predictions wait in a queue and each strobed result is checked
// against the oldest one.
module tb_top;
    import bia_pkg::*;

    // one result: addressed bit before the item, lowest free id after it
    typedef struct packed {
        logic              was_set;
        logic [FREE_W-1:0] first_free;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_operation;
    logic [IDX_W-1:0]  i_bit_index;
    logic              o_result_strobe;
    logic              o_bit_was_set;
    logic [FREE_W-1:0] o_first_free;

    // bench copy of the in-use map and its current lowest free id
    logic [WORD_BITS-1:0] usage_map [WORD_COUNT];
    logic [FREE_W-1:0]    free_head;

    t_answer     answer_q[$];
    t_answer     head_ans;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned full_seen;
    int unsigned op_seen [4];
    int unsigned burst_left;
    int unsigned guard;

    bitmap_id_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_bit_index     (i_bit_index),
        .o_result_strobe (o_result_strobe),
        .o_bit_was_set   (o_bit_was_set),
        .o_first_free    (o_first_free)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop, well past the slowest legal run (~1600 items)
    initial begin
        #2_000_000;
        $display("ERROR: timeout, %0d results still outstanding", answer_q.size());
        $display("Regression FAIL");
        $finish;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    // word-ordered scan for the lowest clear bit; full map gives capacity
    function automatic logic [FREE_W-1:0] scan_first_free();
        for (int w = 0; w < WORD_COUNT; w++) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (!usage_map[w][b]) begin
                    return FREE_W'(w * WORD_BITS + b);
                end
            end
        end
        return FREE_W'(CAPACITY);
    endfunction

    // update the map for one item and return the result it must produce
    function automatic t_answer apply_request(input t_op op, input logic [IDX_W-1:0] idx);
        t_answer     ans;
        int unsigned w;
        int unsigned b;
        w = idx / WORD_BITS;
        b = idx % WORD_BITS;
        ans.was_set = 1'b0;
        // out-of-range word cannot happen at the default size, kept for safety
        if (w < WORD_COUNT) begin
            ans.was_set = usage_map[w][b];
            case (op)
                OP_SET:   usage_map[w][b] = 1'b1;
                OP_CLEAR: usage_map[w][b] = 1'b0;
                default:  ;  // read and the spare code leave the map alone
            endcase
        end
        ans.first_free = scan_first_free();
        return ans;
    endfunction

    //------------------------------------------------------------------
    // Sender: bursts of back-to-back items with random gaps between them
    //------------------------------------------------------------------

    // start stays high across a burst, so it is never dropped and raised in
    // the same step; between bursts it is held low for a random gap
    task automatic send_item(input t_op op, input logic [IDX_W-1:0] idx);
        t_answer ans;
        start       <= 1'b1;
        i_operation <= op;
        i_bit_index <= idx;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        // taken at this edge: busy was low with start high
        ans       = apply_request(op, idx);
        free_head = ans.first_free;
        answer_q.push_back(ans);
        op_seen[op]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            // short gaps half the time, long ones to land inside a full scan
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
            // some long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    endtask

    //------------------------------------------------------------------
    // Result checker: no back-pressure, every strobe is a result
    //------------------------------------------------------------------

    task automatic note_mismatch(input string what, input int unsigned expd,
                                 input int unsigned act);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, expd, act);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            results_seen++;
            if (answer_q.size() == 0) begin
                note_mismatch("unexpected result, outstanding count", 0, 1);
            end else begin
                head_ans = answer_q.pop_front();
                if (head_ans.first_free == CAPACITY) begin
                    full_seen++;
                end
                if (o_bit_was_set !== head_ans.was_set) begin
                    note_mismatch("bit_was_set", head_ans.was_set, o_bit_was_set);
                end
                if (o_first_free !== head_ans.first_free) begin
                    note_mismatch("first_free", head_ans.first_free, o_first_free);
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // field extremes, every op code, set on set / clear on clear, spare op
    task automatic test_directed();
        send_item(OP_READ, '0);
        send_item(OP_READ, IDX_W'(CAPACITY - 1));
        send_item(OP_SPARE, IDX_W'(5));
        send_item(OP_CLEAR, IDX_W'(7));             // free bit freed again
        send_item(OP_SET, '0);
        send_item(OP_SET, '0);                      // already in use
        send_item(OP_SET, IDX_W'(CAPACITY - 1));
        send_item(OP_READ, IDX_W'(CAPACITY - 1));
        send_item(OP_SPARE, IDX_W'(CAPACITY - 1));  // spare code on a set bit
        send_item(OP_SET, IDX_W'(31));              // top bit of word 0
        send_item(OP_SET, IDX_W'(32));              // bottom bit of word 1
        send_item(OP_SET, IDX_W'(682));             // alternating index bits
        send_item(OP_SET, IDX_W'(341));
        send_item(OP_CLEAR, '0);
        send_item(OP_READ, '0);
        send_item(OP_CLEAR, IDX_W'(CAPACITY - 1));
        send_item(OP_CLEAR, IDX_W'(CAPACITY - 1));
        send_item(OP_CLEAR, IDX_W'(341));
        send_item(OP_CLEAR, IDX_W'(682));
        send_item(OP_CLEAR, IDX_W'(31));
        send_item(OP_CLEAR, IDX_W'(32));
    endtask

    // allocator use: grab the lowest free id, free ids near the low end
    task automatic test_alloc_churn(input int unsigned n);
        int unsigned pick;
        int unsigned hi;
        repeat (n) begin
            pick = $urandom_range(0, 9);
            hi   = (free_head + 40 > CAPACITY - 1) ? CAPACITY - 1 : free_head + 40;
            if (pick < 6 && free_head != CAPACITY) begin
                send_item(OP_SET, IDX_W'(free_head));
            end else if (pick < 9) begin
                send_item(OP_CLEAR, IDX_W'($urandom_range(0, hi)));
            end else begin
                send_item(t_op'($urandom_range(0, 3)), IDX_W'($urandom_range(0, CAPACITY - 1)));
            end
        end
    endtask

    // allocate until every id is taken: scan runs through all words
    task automatic test_fill_to_full();
        while (free_head != CAPACITY) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(OP_READ, IDX_W'($urandom_range(0, CAPACITY - 1)));
            end else begin
                send_item(OP_SET, IDX_W'(free_head));
            end
        end
    endtask

    // full map: reads and a set report capacity, free-read-reclaim cycles
    task automatic test_full_map();
        logic [IDX_W-1:0] idx;
        send_item(OP_READ, IDX_W'(CAPACITY - 1));
        send_item(OP_SPARE, '0);
        send_item(OP_SET, IDX_W'(512));
        repeat (20) begin
            idx = IDX_W'($urandom_range(0, CAPACITY - 1));
            send_item(OP_CLEAR, idx);
            send_item(OP_READ, idx);
            send_item(OP_SET, IDX_W'(free_head));
        end
    endtask

    // uniform noise over every op code and index
    task automatic test_random_mix(input int unsigned n);
        repeat (n) begin
            send_item(t_op'($urandom_range(0, 3)), IDX_W'($urandom_range(0, CAPACITY - 1)));
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial begin
        start       <= 1'b0;
        i_operation <= OP_READ;
        i_bit_index <= '0;
        i_rst_n     <= 1'b0;
        mismatches   = 0;
        results_seen = 0;
        full_seen    = 0;
        burst_left   = 0;
        for (int i = 0; i < 4; i++) begin
            op_seen[i] = 0;
        end
        for (int w = 0; w < WORD_COUNT; w++) begin
            usage_map[w] = '0;
        end
        free_head = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_alloc_churn(200);
        test_fill_to_full();
        test_full_map();
        test_random_mix(150);

        // last item is taken at this edge; drop start without a second drive
        start <= 1'b0;

        // drain, then a tail longer than one worst-case scan
        guard = 0;
        while (answer_q.size() != 0 && guard < 500) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            note_mismatch("missing results, outstanding count", 0, answer_q.size());
        end

        $display("Covered %0d items: read %0d, set %0d, clear %0d, spare %0d",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[OP_READ], op_seen[OP_SET], op_seen[OP_CLEAR], op_seen[OP_SPARE]);
        $display("%0d results checked, %0d with the map full, %0d mismatches",
                 results_seen, full_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
